[sv/lorenz_pkg.sv]
// Shared types, codes and microcode for the Lorenz integrator.
// Holds channel payload structs, ALU opcodes, operand codes and the program ROM.
// No dependencies.
package lorenz_pkg;

    localparam int WORD_BITS        = 32;
    localparam int FRAC_BITS        = 20;
    localparam int MAX_PICARD_ITERS = 8;
    localparam int SCRATCH_DEPTH    = 16;
    localparam int PC_W             = 7;
    localparam int IO_W             = 32;
    localparam int STEP_W           = 21;
    localparam int METHOD_W         = 3;
    localparam int PICARD_W         = 4;
    localparam int CFG_IDX_W        = 2;

    // Command beat.
    typedef struct packed {
        logic                   kind;
        logic signed [IO_W-1:0] load_x;
        logic signed [IO_W-1:0] load_y;
        logic signed [IO_W-1:0] load_z;
    } cmd_t;

    // Result beat.
    typedef struct packed {
        logic signed [IO_W-1:0] out_x;
        logic signed [IO_W-1:0] out_y;
        logic signed [IO_W-1:0] out_z;
        logic                   saturated;
    } res_t;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_METHOD = 2'd0;
    localparam cfg_idx_t CFG_STEP   = 2'd1;
    localparam cfg_idx_t CFG_PICARD = 2'd2;

    typedef logic [METHOD_W-1:0] method_t;
    localparam method_t M_EULER  = 3'd0;
    localparam method_t M_HEUN   = 3'd1;
    localparam method_t M_TAYLOR = 3'd2;
    localparam method_t M_PICARD = 3'd3;
    localparam method_t M_RK4    = 3'd4;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_HALF,
        OP_CALL,
        OP_RET,
        OP_DISP,
        OP_JZ,
        OP_JMP,
        OP_END
    } op_t;

    // Operand codes: below 16 address the scratch RAM, above select specials.
    typedef logic [4:0] src_t;
    localparam src_t S_K1X  = 5'd0;
    localparam src_t S_K1Y  = 5'd1;
    localparam src_t S_K1Z  = 5'd2;
    localparam src_t S_ACX  = 5'd3;
    localparam src_t S_ACY  = 5'd4;
    localparam src_t S_ACZ  = 5'd5;
    localparam src_t S_QX   = 5'd6;
    localparam src_t S_QY   = 5'd7;
    localparam src_t S_QZ   = 5'd8;
    localparam src_t S_T0   = 5'd9;
    localparam src_t S_T1   = 5'd10;
    localparam src_t S_DX   = 5'd11;
    localparam src_t S_DY   = 5'd12;
    localparam src_t S_DZ   = 5'd13;
    localparam src_t S_PX   = 5'd16;
    localparam src_t S_PY   = 5'd17;
    localparam src_t S_PZ   = 5'd18;
    localparam src_t S_SIG  = 5'd19;
    localparam src_t S_RHO  = 5'd20;
    localparam src_t S_BETA = 5'd21;
    localparam src_t S_H    = 5'd22;
    localparam src_t S_HH   = 5'd23;
    localparam src_t S_H6   = 5'd24;
    localparam src_t S_ZERO = 5'd25;

    typedef logic [PC_W-1:0] pc_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        src_t d;
        pc_t  tgt;
    } uop_t;

    localparam pc_t PC_DERIV    = 7'd8;
    localparam pc_t PC_EULER    = 7'd17;
    localparam pc_t PC_HEUN     = 7'd24;
    localparam pc_t PC_TAYLOR   = 7'd41;
    localparam pc_t PC_PIC      = 7'd68;
    localparam pc_t PC_PIC_EXIT = 7'd80;
    localparam pc_t PC_RK4      = 7'd84;
    localparam pc_t PC_LAST     = 7'd126;

    function automatic uop_t mk(input op_t op, input src_t a, input src_t b, input src_t d);
        uop_t u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.d   = d;
        u.tgt = '0;
        return u;
    endfunction

    function automatic uop_t mkj(input op_t op, input pc_t tgt);
        uop_t u;
        u.op  = op;
        u.a   = S_ZERO;
        u.b   = S_ZERO;
        u.d   = S_ZERO;
        u.tgt = tgt;
        return u;
    endfunction

    function automatic pc_t method_entry(input method_t m);
        pc_t p;
        case (m)
            M_EULER:  p = PC_EULER;
            M_HEUN:   p = PC_HEUN;
            M_TAYLOR: p = PC_TAYLOR;
            M_PICARD: p = PC_PIC;
            default:  p = PC_RK4;
        endcase
        return p;
    endfunction

    // (h + 3) / 6 through a reciprocal; exact for h below 2^23.
    function automatic logic [STEP_W-1:0] div6(input logic [STEP_W-1:0] h);
        logic [STEP_W:0]   t;
        logic [45:0]       m;
        t = {1'b0, h} + (STEP_W+1)'(3);
        m = 46'(t) * 46'd5592406;
        return m[45:25];
    endfunction

    // Program ROM. Derivative routine reads Q and writes D.
    function automatic uop_t ucode(input pc_t pc);
        uop_t u;
        case (pc)
            // prologue: Q = P, K1 = f(P), branch on method
            7'd0:   u = mk(OP_ADD, S_PX, S_ZERO, S_QX);
            7'd1:   u = mk(OP_ADD, S_PY, S_ZERO, S_QY);
            7'd2:   u = mk(OP_ADD, S_PZ, S_ZERO, S_QZ);
            7'd3:   u = mkj(OP_CALL, PC_DERIV);
            7'd4:   u = mk(OP_ADD, S_DX, S_ZERO, S_K1X);
            7'd5:   u = mk(OP_ADD, S_DY, S_ZERO, S_K1Y);
            7'd6:   u = mk(OP_ADD, S_DZ, S_ZERO, S_K1Z);
            7'd7:   u = mkj(OP_DISP, '0);
            // derivative
            7'd8:   u = mk(OP_SUB, S_QY, S_QX, S_T0);
            7'd9:   u = mk(OP_MUL, S_SIG, S_T0, S_DX);
            7'd10:  u = mk(OP_SUB, S_RHO, S_QZ, S_T0);
            7'd11:  u = mk(OP_MUL, S_QX, S_T0, S_T0);
            7'd12:  u = mk(OP_SUB, S_T0, S_QY, S_DY);
            7'd13:  u = mk(OP_MUL, S_QX, S_QY, S_T0);
            7'd14:  u = mk(OP_MUL, S_BETA, S_QZ, S_T1);
            7'd15:  u = mk(OP_SUB, S_T0, S_T1, S_DZ);
            7'd16:  u = mkj(OP_RET, '0);
            // Euler
            7'd17:  u = mk(OP_MUL, S_H, S_K1X, S_T0);
            7'd18:  u = mk(OP_ADD, S_PX, S_T0, S_PX);
            7'd19:  u = mk(OP_MUL, S_H, S_K1Y, S_T0);
            7'd20:  u = mk(OP_ADD, S_PY, S_T0, S_PY);
            7'd21:  u = mk(OP_MUL, S_H, S_K1Z, S_T0);
            7'd22:  u = mk(OP_ADD, S_PZ, S_T0, S_PZ);
            7'd23:  u = mkj(OP_END, '0);
            // Heun
            7'd24:  u = mk(OP_MUL, S_H, S_K1X, S_T0);
            7'd25:  u = mk(OP_ADD, S_PX, S_T0, S_QX);
            7'd26:  u = mk(OP_MUL, S_H, S_K1Y, S_T0);
            7'd27:  u = mk(OP_ADD, S_PY, S_T0, S_QY);
            7'd28:  u = mk(OP_MUL, S_H, S_K1Z, S_T0);
            7'd29:  u = mk(OP_ADD, S_PZ, S_T0, S_QZ);
            7'd30:  u = mkj(OP_CALL, PC_DERIV);
            7'd31:  u = mk(OP_ADD, S_K1X, S_DX, S_K1X);
            7'd32:  u = mk(OP_ADD, S_K1Y, S_DY, S_K1Y);
            7'd33:  u = mk(OP_ADD, S_K1Z, S_DZ, S_K1Z);
            7'd34:  u = mk(OP_MUL, S_HH, S_K1X, S_T0);
            7'd35:  u = mk(OP_ADD, S_PX, S_T0, S_PX);
            7'd36:  u = mk(OP_MUL, S_HH, S_K1Y, S_T0);
            7'd37:  u = mk(OP_ADD, S_PY, S_T0, S_PY);
            7'd38:  u = mk(OP_MUL, S_HH, S_K1Z, S_T0);
            7'd39:  u = mk(OP_ADD, S_PZ, S_T0, S_PZ);
            7'd40:  u = mkj(OP_END, '0);
            // Taylor: second derivative into Q, hq into DX
            7'd41:  u = mk(OP_SUB, S_K1Y, S_K1X, S_T0);
            7'd42:  u = mk(OP_MUL, S_SIG, S_T0, S_QX);
            7'd43:  u = mk(OP_SUB, S_RHO, S_PZ, S_T0);
            7'd44:  u = mk(OP_MUL, S_K1X, S_T0, S_T0);
            7'd45:  u = mk(OP_MUL, S_K1Z, S_PX, S_T1);
            7'd46:  u = mk(OP_SUB, S_T0, S_T1, S_T0);
            7'd47:  u = mk(OP_SUB, S_T0, S_K1Y, S_QY);
            7'd48:  u = mk(OP_MUL, S_K1Y, S_PX, S_T0);
            7'd49:  u = mk(OP_MUL, S_K1X, S_PY, S_T1);
            7'd50:  u = mk(OP_ADD, S_T0, S_T1, S_T0);
            7'd51:  u = mk(OP_MUL, S_BETA, S_K1Z, S_T1);
            7'd52:  u = mk(OP_SUB, S_T0, S_T1, S_QZ);
            7'd53:  u = mk(OP_MUL, S_H, S_H, S_T0);
            7'd54:  u = mk(OP_HALF, S_T0, S_ZERO, S_DX);
            7'd55:  u = mk(OP_MUL, S_H, S_K1X, S_T0);
            7'd56:  u = mk(OP_ADD, S_PX, S_T0, S_T0);
            7'd57:  u = mk(OP_MUL, S_DX, S_QX, S_T1);
            7'd58:  u = mk(OP_ADD, S_T0, S_T1, S_PX);
            7'd59:  u = mk(OP_MUL, S_H, S_K1Y, S_T0);
            7'd60:  u = mk(OP_ADD, S_PY, S_T0, S_T0);
            7'd61:  u = mk(OP_MUL, S_DX, S_QY, S_T1);
            7'd62:  u = mk(OP_ADD, S_T0, S_T1, S_PY);
            7'd63:  u = mk(OP_MUL, S_H, S_K1Z, S_T0);
            7'd64:  u = mk(OP_ADD, S_PZ, S_T0, S_T0);
            7'd65:  u = mk(OP_MUL, S_DX, S_QZ, S_T1);
            7'd66:  u = mk(OP_ADD, S_T0, S_T1, S_PZ);
            7'd67:  u = mkj(OP_END, '0);
            // Picard
            7'd68:  u = mkj(OP_JZ, PC_PIC_EXIT);
            7'd69:  u = mkj(OP_CALL, PC_DERIV);
            7'd70:  u = mk(OP_ADD, S_K1X, S_DX, S_DX);
            7'd71:  u = mk(OP_ADD, S_K1Y, S_DY, S_DY);
            7'd72:  u = mk(OP_ADD, S_K1Z, S_DZ, S_DZ);
            7'd73:  u = mk(OP_MUL, S_HH, S_DX, S_T0);
            7'd74:  u = mk(OP_ADD, S_PX, S_T0, S_QX);
            7'd75:  u = mk(OP_MUL, S_HH, S_DY, S_T0);
            7'd76:  u = mk(OP_ADD, S_PY, S_T0, S_QY);
            7'd77:  u = mk(OP_MUL, S_HH, S_DZ, S_T0);
            7'd78:  u = mk(OP_ADD, S_PZ, S_T0, S_QZ);
            7'd79:  u = mkj(OP_JMP, PC_PIC);
            7'd80:  u = mk(OP_ADD, S_QX, S_ZERO, S_PX);
            7'd81:  u = mk(OP_ADD, S_QY, S_ZERO, S_PY);
            7'd82:  u = mk(OP_ADD, S_QZ, S_ZERO, S_PZ);
            7'd83:  u = mkj(OP_END, '0);
            // RK4
            7'd84:  u = mk(OP_MUL, S_HH, S_K1X, S_T0);
            7'd85:  u = mk(OP_ADD, S_PX, S_T0, S_QX);
            7'd86:  u = mk(OP_MUL, S_HH, S_K1Y, S_T0);
            7'd87:  u = mk(OP_ADD, S_PY, S_T0, S_QY);
            7'd88:  u = mk(OP_MUL, S_HH, S_K1Z, S_T0);
            7'd89:  u = mk(OP_ADD, S_PZ, S_T0, S_QZ);
            7'd90:  u = mkj(OP_CALL, PC_DERIV);
            7'd91:  u = mk(OP_ADD, S_DX, S_DX, S_ACX);
            7'd92:  u = mk(OP_ADD, S_K1X, S_ACX, S_ACX);
            7'd93:  u = mk(OP_ADD, S_DY, S_DY, S_ACY);
            7'd94:  u = mk(OP_ADD, S_K1Y, S_ACY, S_ACY);
            7'd95:  u = mk(OP_ADD, S_DZ, S_DZ, S_ACZ);
            7'd96:  u = mk(OP_ADD, S_K1Z, S_ACZ, S_ACZ);
            7'd97:  u = mk(OP_MUL, S_HH, S_DX, S_T0);
            7'd98:  u = mk(OP_ADD, S_PX, S_T0, S_QX);
            7'd99:  u = mk(OP_MUL, S_HH, S_DY, S_T0);
            7'd100: u = mk(OP_ADD, S_PY, S_T0, S_QY);
            7'd101: u = mk(OP_MUL, S_HH, S_DZ, S_T0);
            7'd102: u = mk(OP_ADD, S_PZ, S_T0, S_QZ);
            7'd103: u = mkj(OP_CALL, PC_DERIV);
            7'd104: u = mk(OP_ADD, S_DX, S_DX, S_K1X);
            7'd105: u = mk(OP_ADD, S_DY, S_DY, S_K1Y);
            7'd106: u = mk(OP_ADD, S_DZ, S_DZ, S_K1Z);
            7'd107: u = mk(OP_MUL, S_H, S_DX, S_T0);
            7'd108: u = mk(OP_ADD, S_PX, S_T0, S_QX);
            7'd109: u = mk(OP_MUL, S_H, S_DY, S_T0);
            7'd110: u = mk(OP_ADD, S_PY, S_T0, S_QY);
            7'd111: u = mk(OP_MUL, S_H, S_DZ, S_T0);
            7'd112: u = mk(OP_ADD, S_PZ, S_T0, S_QZ);
            7'd113: u = mkj(OP_CALL, PC_DERIV);
            7'd114: u = mk(OP_ADD, S_K1X, S_DX, S_K1X);
            7'd115: u = mk(OP_ADD, S_K1Y, S_DY, S_K1Y);
            7'd116: u = mk(OP_ADD, S_K1Z, S_DZ, S_K1Z);
            7'd117: u = mk(OP_ADD, S_ACX, S_K1X, S_ACX);
            7'd118: u = mk(OP_ADD, S_ACY, S_K1Y, S_ACY);
            7'd119: u = mk(OP_ADD, S_ACZ, S_K1Z, S_ACZ);
            7'd120: u = mk(OP_MUL, S_H6, S_ACX, S_T0);
            7'd121: u = mk(OP_ADD, S_PX, S_T0, S_PX);
            7'd122: u = mk(OP_MUL, S_H6, S_ACY, S_T0);
            7'd123: u = mk(OP_ADD, S_PY, S_T0, S_PY);
            7'd124: u = mk(OP_MUL, S_H6, S_ACZ, S_T0);
            7'd125: u = mk(OP_ADD, S_PZ, S_T0, S_PZ);
            default: u = mkj(OP_END, '0);
        endcase
        return u;
    endfunction

endpackage

[sv/lorenz_ode_integrator_top.sv]
// Lorenz system integrator: sequencer, point registers, scratch RAM and shared ALU.
// Depends on lorenz_pkg, lorenz_ram and lorenz_alu.
//
//   channel | signals                                   | direction | beat
//   cmd     | cmd_valid, cmd_stall, cmd                 | in        | load or advance request
//   res     | res_valid, res_stall, res                 | out       | point after the request
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | register write
//
// A load beat goes from idle to the done state. An advance beat runs the program
// ROM one micro-op at a time (RAM read, then ALU and write-back) through the single
// ALU, from the prologue through the routine of the selected method. The result
// beat turns valid as the done state returns to idle. cmd_stall is high while a beat
// is in flight; an item that finishes while the previous result is still held waits
// in the done state until that beat is taken. Reset is asynchronous and sets the
// point to 1.0 and the registers to RK4, h = 10486, three Picard iterations.
module lorenz_ode_integrator_top #(
    parameter int WORD_BITS        = lorenz_pkg::WORD_BITS,
    parameter int FRAC_BITS        = lorenz_pkg::FRAC_BITS,
    parameter int MAX_PICARD_ITERS = lorenz_pkg::MAX_PICARD_ITERS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  lorenz_pkg::cmd_t                    cmd,
    output logic                                res_valid,
    input  logic                                res_stall,
    output lorenz_pkg::res_t                    res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lorenz_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lorenz_pkg::STEP_W-1:0]       cfg_data
);
    import lorenz_pkg::*;

    localparam int W      = WORD_BITS;
    localparam int EXT_W  = (W > IO_W ? W : IO_W) + 1;
    localparam int CNT_W  = $clog2(MAX_PICARD_ITERS + 1);
    localparam int CMP_W  = (CNT_W > PICARD_W ? CNT_W : PICARD_W);
    localparam int ADDR_W = $clog2(SCRATCH_DEPTH);

    localparam logic [W-1:0] ONE_Q  = W'(64'd1 << FRAC_BITS);
    localparam logic [W-1:0] SIG_Q  = W'(64'd10 << FRAC_BITS);
    localparam logic [W-1:0] RHO_Q  = W'(64'd28 << FRAC_BITS);
    localparam logic [W-1:0] BETA_Q = W'(((64'd8 << FRAC_BITS) * 2 + 3) / 6);

    localparam logic signed [EXT_W-1:0] W_MAX_E   = (EXT_W'(1) << (W - 1)) - EXT_W'(1);
    localparam logic signed [EXT_W-1:0] W_MIN_E   = -W_MAX_E - EXT_W'(1);
    localparam logic signed [EXT_W-1:0] OUT_MAX_E = (EXT_W'(1) << (IO_W - 1)) - EXT_W'(1);
    localparam logic signed [EXT_W-1:0] OUT_MIN_E = -OUT_MAX_E - EXT_W'(1);
    localparam logic [CMP_W-1:0]        MAX_IT    = CMP_W'(MAX_PICARD_ITERS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DONE
    } state_t;

    // configuration registers
    method_t               method_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [PICARD_W-1:0]   picard_reg;
    logic [W-1:0]          h6_reg;

    // sequencer and datapath state
    state_t                state_reg;
    pc_t                   pc_reg;
    pc_t                   ret_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  sat_reg;
    logic signed [W-1:0]   px_reg;
    logic signed [W-1:0]   py_reg;
    logic signed [W-1:0]   pz_reg;
    logic                  res_valid_reg;
    res_t                  res_reg;

    uop_t                  uop;
    logic [W-1:0]          ram_rd_a;
    logic [W-1:0]          ram_rd_b;
    logic signed [W-1:0]   opa;
    logic signed [W-1:0]   opb;
    logic signed [W-1:0]   alu_res;
    logic                  alu_sat;
    logic                  is_alu;
    logic                  ram_we;
    logic                  cmd_acc;
    logic [CMP_W-1:0]      pic_ext;
    logic [CNT_W-1:0]      iter_init;
    logic [W-1:0]          hh;

    logic signed [EXT_W-1:0] ld_ext [3];
    logic signed [W-1:0]     ld_clip [3];
    logic [2:0]              ld_sat;
    logic signed [EXT_W-1:0] pt_ext [3];
    logic signed [IO_W-1:0]  pt_clip [3];
    logic [2:0]              pt_sat;

    assign uop       = ucode(pc_reg);
    assign is_alu    = (uop.op == OP_ADD) || (uop.op == OP_SUB) ||
                       (uop.op == OP_MUL) || (uop.op == OP_HALF);
    assign ram_we    = (state_reg == S_EXEC) && is_alu && !uop.d[4];
    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign hh        = W'(({1'b0, step_reg} + (STEP_W+1)'(1)) >> 1);

    // Picard count, clipped to the largest supported iteration count.
    assign pic_ext   = CMP_W'(picard_reg);
    assign iter_init = (pic_ext > MAX_IT) ? CNT_W'(MAX_IT) : CNT_W'(pic_ext);

    // Operand select: scratch RAM, point registers or constants.
    always_comb
    begin
        case (uop.a)
            S_PX:    opa = px_reg;
            S_PY:    opa = py_reg;
            S_PZ:    opa = pz_reg;
            S_SIG:   opa = SIG_Q;
            S_RHO:   opa = RHO_Q;
            S_BETA:  opa = BETA_Q;
            S_H:     opa = W'(step_reg);
            S_HH:    opa = hh;
            S_H6:    opa = h6_reg;
            S_ZERO:  opa = '0;
            default: opa = ram_rd_a;
        endcase
        case (uop.b)
            S_PX:    opb = px_reg;
            S_PY:    opb = py_reg;
            S_PZ:    opb = pz_reg;
            S_SIG:   opb = SIG_Q;
            S_RHO:   opb = RHO_Q;
            S_BETA:  opb = BETA_Q;
            S_H:     opb = W'(step_reg);
            S_HH:    opb = hh;
            S_H6:    opb = h6_reg;
            S_ZERO:  opb = '0;
            default: opb = ram_rd_b;
        endcase
    end

    // Clip loaded values into the word and the point into the 32-bit result.
    always_comb
    begin
        ld_ext[0] = EXT_W'(cmd.load_x);
        ld_ext[1] = EXT_W'(cmd.load_y);
        ld_ext[2] = EXT_W'(cmd.load_z);
        pt_ext[0] = EXT_W'(px_reg);
        pt_ext[1] = EXT_W'(py_reg);
        pt_ext[2] = EXT_W'(pz_reg);
        for (int i = 0; i < 3; i++)
        begin
            ld_sat[i] = (ld_ext[i] > W_MAX_E) || (ld_ext[i] < W_MIN_E);
            if (ld_ext[i] > W_MAX_E)
                ld_clip[i] = W'(W_MAX_E);
            else if (ld_ext[i] < W_MIN_E)
                ld_clip[i] = W'(W_MIN_E);
            else
                ld_clip[i] = W'(ld_ext[i]);
            pt_sat[i] = (pt_ext[i] > OUT_MAX_E) || (pt_ext[i] < OUT_MIN_E);
            if (pt_ext[i] > OUT_MAX_E)
                pt_clip[i] = IO_W'(OUT_MAX_E);
            else if (pt_ext[i] < OUT_MIN_E)
                pt_clip[i] = IO_W'(OUT_MIN_E);
            else
                pt_clip[i] = IO_W'(pt_ext[i]);
        end
    end

    lorenz_ram #(
        .WIDTH (W),
        .DEPTH (SCRATCH_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (uop.d[ADDR_W-1:0]),
        .wdata   (alu_res),
        .raddr_a (uop.a[ADDR_W-1:0]),
        .raddr_b (uop.b[ADDR_W-1:0]),
        .rdata_a (ram_rd_a),
        .rdata_b (ram_rd_b)
    );

    lorenz_alu #(
        .WORD_BITS (W),
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .op  (uop.op),
        .a   (opa),
        .b   (opb),
        .res (alu_res),
        .sat (alu_sat)
    );

    // Configuration registers; h/6 is kept in a register of its own.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg <= M_RK4;
            step_reg   <= STEP_W'(10486);
            picard_reg <= PICARD_W'(3);
            h6_reg     <= '0;
        end
        else
        begin
            h6_reg <= W'(div6(step_reg));
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_METHOD: method_reg <= cfg_data[METHOD_W-1:0];
                    CFG_STEP:   step_reg   <= cfg_data;
                    CFG_PICARD: picard_reg <= cfg_data[PICARD_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // Sequencer: fetch a micro-op, read operands, execute and write back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            ret_reg       <= '0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            px_reg        <= ONE_Q;
            py_reg        <= ONE_Q;
            pz_reg        <= ONE_Q;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            // drop the result beat once it is taken; the done state reloads it
            if (res_valid_reg && !res_stall && state_reg != S_DONE)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_acc)
                    begin
                        if (cmd.kind == KIND_LOAD)
                        begin
                            px_reg    <= ld_clip[0];
                            py_reg    <= ld_clip[1];
                            pz_reg    <= ld_clip[2];
                            sat_reg   <= |ld_sat;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            sat_reg   <= 1'b0;
                            pc_reg    <= '0;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_READ;
                    unique case (uop.op) inside
                        OP_ADD, OP_SUB, OP_MUL, OP_HALF:
                        begin
                            sat_reg <= sat_reg | alu_sat;
                            if (uop.d == S_PX)
                                px_reg <= alu_res;
                            if (uop.d == S_PY)
                                py_reg <= alu_res;
                            if (uop.d == S_PZ)
                                pz_reg <= alu_res;
                            pc_reg <= pc_reg + PC_W'(1);
                        end
                        OP_CALL:
                        begin
                            ret_reg <= pc_reg + PC_W'(1);
                            pc_reg  <= uop.tgt;
                        end
                        OP_RET:
                        begin
                            pc_reg <= ret_reg;
                        end
                        OP_DISP:
                        begin
                            cnt_reg <= iter_init;
                            pc_reg  <= method_entry(method_reg);
                        end
                        OP_JZ:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pc_reg <= uop.tgt;
                            end
                            else
                            begin
                                cnt_reg <= cnt_reg - CNT_W'(1);
                                pc_reg  <= pc_reg + PC_W'(1);
                            end
                        end
                        OP_JMP:
                        begin
                            pc_reg <= uop.tgt;
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_DONE:
                begin
                    // hold until the result register is free
                    if (!res_valid_reg || !res_stall)
                    begin
                        res_reg.out_x     <= pt_clip[0];
                        res_reg.out_y     <= pt_clip[1];
                        res_reg.out_z     <= pt_clip[2];
                        res_reg.saturated <= sat_reg | (|pt_sat);
                        res_valid_reg     <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The scratch RAM is written only while a micro-op executes.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_EXEC))
        else $error("scratch write outside execute");

    // The program counter stays inside the program.
    assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_LAST)
        else $error("program counter out of range");

    // The Picard counter never exceeds the supported iteration count.
    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(cnt_reg) <= MAX_IT)
        else $error("iteration count out of range");

    // A new result only comes from the done state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> ($past(state_reg) == S_DONE))
        else $error("result without completed item");

    // A load beat goes straight to completion.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && cmd.kind == KIND_LOAD) |=> (state_reg == S_DONE))
        else $error("load did not complete");
endmodule

[sv/lorenz_ram.sv]
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module lorenz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

[sv/lorenz_alu.sv]
// Shared saturating fixed-point unit: add, subtract, rounded multiply, halve.
// Depends on lorenz_pkg for the opcode type.
module lorenz_alu #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 20
) (
    input  lorenz_pkg::op_t              op,
    input  logic signed [WORD_BITS-1:0]  a,
    input  logic signed [WORD_BITS-1:0]  b,
    output logic signed [WORD_BITS-1:0]  res,
    output logic                         sat
);
    import lorenz_pkg::*;

    localparam int W     = WORD_BITS;
    localparam int MAG_W = 2 * W + 1 - FRAC_BITS;
    localparam logic [W-1:0]     SMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]     SMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic [2*W:0]     HALF_R = (2*W+1)'(1) << (FRAC_BITS - 1);
    localparam logic [MAG_W-1:0] LIM_P  = MAG_W'(SMAX);
    localparam logic [MAG_W-1:0] LIM_N  = MAG_W'(SMIN);

    logic [W-1:0]     ua;
    logic [W-1:0]     ub;
    logic [2*W-1:0]   prod;
    logic [2*W:0]     rnd;
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [W:0]       s;

    always_comb
    begin
        ua   = a[W-1] ? ($unsigned(~a) + W'(1)) : $unsigned(a);
        ub   = b[W-1] ? ($unsigned(~b) + W'(1)) : $unsigned(b);
        prod = (2*W)'(ua) * (2*W)'(ub);
        rnd  = {1'b0, prod} + HALF_R;
        mag  = rnd[2*W:FRAC_BITS];
        neg  = a[W-1] ^ b[W-1];
        s    = '0;
        res  = '0;
        sat  = 1'b0;
        case (op)
            OP_ADD, OP_SUB:
            begin
                if (op == OP_ADD)
                    s = {a[W-1], a} + {b[W-1], b};
                else
                    s = {a[W-1], a} - {b[W-1], b};
                if (s[W] != s[W-1])
                begin
                    sat = 1'b1;
                    res = s[W] ? SMIN : SMAX;
                end
                else
                begin
                    res = s[W-1:0];
                end
            end
            OP_MUL:
            begin
                if (!neg && mag > LIM_P)
                begin
                    sat = 1'b1;
                    res = SMAX;
                end
                else if (neg && mag > LIM_N)
                begin
                    sat = 1'b1;
                    res = SMIN;
                end
                else
                begin
                    res = neg ? (~mag[W-1:0] + W'(1)) : mag[W-1:0];
                end
            end
            OP_HALF:
            begin
                s   = {a[W-1], a} + (W+1)'(1);
                res = s[W:1];
            end
            default:
            begin
                res = '0;
            end
        endcase
    end
endmodule

[sim/lorenz_ode_integrator_top_tb.sv]
// Self-checking testbench for lorenz_ode_integrator_top: directed and random load/advance
// beats across all integration methods, checked against a fixed-point Lorenz predictor.
// Depends on lorenz_pkg and the integrator RTL.
module lorenz_ode_integrator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lorenz_pkg::*;

    typedef longint trip_t [3];

    localparam longint WMAX   = 64'sd2147483647;
    localparam longint WMIN   = -64'sd2147483648;
    localparam longint ONE_Q  = 64'sd1 << FRAC_BITS;
    localparam longint SIG_Q  = 64'sd10 << FRAC_BITS;
    localparam longint RHO_Q  = 64'sd28 << FRAC_BITS;
    localparam longint BETA_Q = ((64'sd8 << FRAC_BITS) * 2 + 3) / 6;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    cmd_t               cmd = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    res_t               res;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_METHOD;
    logic [STEP_W-1:0]  cfg_data = '0;

    lorenz_ode_integrator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Predictor state: the held point and the register shadow copies.
    trip_t   point_q = '{ONE_Q, ONE_Q, ONE_Q};
    method_t method_q = M_RK4;
    longint  step_q = 10486;
    int      picard_q = 3;
    bit      clip_seen;

    cmd_t    pending_cmds [$];
    res_t    expected_pts [$];
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      mismatches = 0;

    function automatic longint clampw(longint v);
        if (v > WMAX) begin clip_seen = 1'b1; return WMAX; end
        if (v < WMIN) begin clip_seen = 1'b1; return WMIN; end
        return v;
    endfunction

    function automatic longint qadd(longint a, longint b);
        return clampw(a + b);
    endfunction

    function automatic longint qsub(longint a, longint b);
        return clampw(a - b);
    endfunction

    // Exact product, round half away from zero, then saturate.
    function automatic longint qmul(longint a, longint b);
        bit              neg;
        longint unsigned ua, ub, mag;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        mag = (ua * ub + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (!neg) begin
            if (mag > 64'd2147483647) begin clip_seen = 1'b1; return WMAX; end
            return longint'(mag);
        end
        if (mag > 64'd2147483648) begin clip_seen = 1'b1; return WMIN; end
        return -longint'(mag);
    endfunction

    function automatic trip_t lorenz_rate(trip_t p);
        trip_t d;
        d[0] = qmul(SIG_Q, qsub(p[1], p[0]));
        d[1] = qsub(qmul(p[0], qsub(RHO_Q, p[2])), p[1]);
        d[2] = qsub(qmul(p[0], p[1]), qmul(BETA_Q, p[2]));
        return d;
    endfunction

    function automatic trip_t lorenz_curv(trip_t p, trip_t f);
        trip_t g;
        g[0] = qmul(SIG_Q, qsub(f[1], f[0]));
        g[1] = qsub(qsub(qmul(f[0], qsub(RHO_Q, p[2])), qmul(f[2], p[0])), f[1]);
        g[2] = qsub(qadd(qmul(f[1], p[0]), qmul(f[0], p[1])), qmul(BETA_Q, f[2]));
        return g;
    endfunction

    function automatic trip_t scaled_add(trip_t p, longint k, trip_t d);
        trip_t r;
        for (int i = 0; i < 3; i++) r[i] = qadd(p[i], qmul(k, d[i]));
        return r;
    endfunction

    function automatic trip_t vec_add(trip_t a, trip_t b);
        trip_t r;
        for (int i = 0; i < 3; i++) r[i] = qadd(a[i], b[i]);
        return r;
    endfunction

    function automatic trip_t integrate_step(trip_t p);
        longint h, hh, hq;
        trip_t  k1, k2, k3, k4, q;
        int     n;
        h  = step_q;
        hh = (h + 1) >>> 1;
        k1 = lorenz_rate(p);
        case (method_q)
            M_EULER: return scaled_add(p, h, k1);
            M_HEUN: begin
                k2 = lorenz_rate(scaled_add(p, h, k1));
                return scaled_add(p, hh, vec_add(k1, k2));
            end
            M_TAYLOR: begin
                hq = (qmul(h, h) + 1) >>> 1;
                return scaled_add(scaled_add(p, h, k1), hq, lorenz_curv(p, k1));
            end
            M_PICARD: begin
                n = (picard_q > MAX_PICARD_ITERS) ? MAX_PICARD_ITERS : picard_q;
                q = p;
                for (int i = 0; i < n; i++)
                    q = scaled_add(p, hh, vec_add(k1, lorenz_rate(q)));
                return q;
            end
            default: begin
                k2 = lorenz_rate(scaled_add(p, hh, k1));
                k3 = lorenz_rate(scaled_add(p, hh, k2));
                k4 = lorenz_rate(scaled_add(p, h, k3));
                q  = vec_add(vec_add(k1, vec_add(k2, k2)), vec_add(vec_add(k3, k3), k4));
                return scaled_add(p, (h + 3) / 6, q);
            end
        endcase
    endfunction

    function automatic res_t predict_point(cmd_t c);
        res_t r;
        clip_seen = 1'b0;
        if (c.kind == KIND_LOAD)
            point_q = '{longint'(c.load_x), longint'(c.load_y), longint'(c.load_z)};
        else
            point_q = integrate_step(point_q);
        r.out_x     = point_q[0][31:0];
        r.out_y     = point_q[1][31:0];
        r.out_z     = point_q[2][31:0];
        r.saturated = clip_seen;
        return r;
    endfunction

    // Driver: hold a stalled beat, otherwise advance to the next pending one or idle.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cmd_valid && !cmd_stall)
                expected_pts.push_back(predict_point(cmd));
            if (!cmd_valid || !cmd_stall) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd       <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result beat with the oldest expectation.
    always @(posedge clk) begin
        res_t exp_r;
        if (rst_n) begin
            if (res_valid && !res_stall) begin
                if (expected_pts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat x=%h y=%h z=%h sat=%b",
                                 res.out_x, res.out_y, res.out_z, res.saturated);
                end else begin
                    exp_r = expected_pts.pop_front();
                    if (res !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("point mismatch: exp x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                                     exp_r.out_x, exp_r.out_y, exp_r.out_z, exp_r.saturated,
                                     res.out_x, res.out_y, res.out_z, res.saturated);
                    end
                end
            end
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Register write; update the shadow copy at the accepting edge.
    task automatic write_reg(cfg_idx_t idx, int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[STEP_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_METHOD: method_q = method_t'(value & 7);
            CFG_STEP:   step_q   = value & 21'h1FFFFF;
            CFG_PICARD: picard_q = value & 15;
            default: ;
        endcase
    endtask

    task automatic drain();
        do @(posedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || expected_pts.size() != 0);
        repeat (400) @(posedge clk);
    endtask

    task automatic set_mode(int mode);
        send_idle_pct  = (mode == 1 || mode == 3) ? ((mode == 3) ? 31 : 79) : 0;
        recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 31 : 79) : 0;
    endtask

    task automatic push_load(int x, int y, int z);
        cmd_t c;
        c.kind   = KIND_LOAD;
        c.load_x = x;
        c.load_y = y;
        c.load_z = z;
        pending_cmds.push_back(c);
    endtask

    task automatic push_advance();
        cmd_t c;
        c.kind   = KIND_ADVANCE;
        c.load_x = $urandom;
        c.load_y = $urandom;
        c.load_z = $urandom;
        pending_cmds.push_back(c);
    endtask

    task automatic directed_phase(int method, int step, int picard);
        write_reg(CFG_METHOD, method);
        write_reg(CFG_STEP, step);
        write_reg(CFG_PICARD, picard);
        push_load(32'sd1 << FRAC_BITS, -(32'sd3 << FRAC_BITS), 25 << FRAC_BITS);
        push_advance();
        drain();
    endtask

    initial begin
        int n, step, adv;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset point and extreme loads under the reset settings.
        set_mode(0);
        push_advance();
        push_load(32'h7FFFFFFF, 32'h80000000, 0);
        push_advance();
        push_load(-1, 32'h80000000, 32'h7FFFFFFF);
        push_advance();
        drain();
        // Every method, unused codes, zero/unity/oversize steps, Picard count edges.
        directed_phase(M_EULER, 0, 3);
        directed_phase(M_HEUN, 1048576, 3);
        directed_phase(M_TAYLOR, 2097151, 3);
        directed_phase(M_PICARD, 10486, 0);
        directed_phase(M_PICARD, 10486, 15);
        directed_phase(M_PICARD, 1, 1);
        directed_phase(5, 10486, 8);
        directed_phase(6, 1, 8);
        directed_phase(7, 1048576, 8);
        write_reg(cfg_idx_t'(3), $urandom);

        // Random: well-formed load-then-advance runs, with some raw full-range loads.
        for (int ph = 0; ph < 12; ph++) begin
            set_mode(ph % 4);
            case ($urandom_range(3))
                0: step = 1;
                1: step = 1048576;
                default: step = $urandom_range(20000, 1);
            endcase
            if (ph == 11) step = 2097151;
            write_reg(CFG_METHOD, (ph < 8) ? ph % 5 : $urandom_range(7));
            write_reg(CFG_STEP, step);
            write_reg(CFG_PICARD, (ph % 6 == 5) ? $urandom_range(15) : $urandom_range(8, 1));
            n = 0;
            while (n < 55) begin
                if ($urandom_range(99) < 12) begin
                    push_load($urandom, $urandom, $urandom);
                end else begin
                    push_load(int'($urandom_range(40 << FRAC_BITS)) - (20 << FRAC_BITS),
                              int'($urandom_range(50 << FRAC_BITS)) - (25 << FRAC_BITS),
                              int'($urandom_range(50 << FRAC_BITS)));
                end
                adv = $urandom_range(8, 2);
                repeat (adv) push_advance();
                n += adv + 1;
            end
            drain();
        end

        if (mismatches == 0 && expected_pts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
